FILE: hdl/sic_pkg.sv
package sic_pkg;

  // Fraction bits of a coordinate.
  localparam int FRAC = 16;
  // Quotient bits produced by the divider, one per pipeline step.
  localparam int DIV_BITS = 32;

  localparam logic [62:0] PAR_TOL_RESET = 63'd429497;
  localparam logic [30:0] VTX_TOL_RESET = 31'd7;

  localparam logic CFG_PAR_TOL = 1'b0;
  localparam logic CFG_VTX_TOL = 1'b1;

  localparam logic [2:0] OP_SEG_SEG      = 3'd0;
  localparam logic [2:0] OP_LINE_SEG     = 3'd1;
  localparam logic [2:0] OP_SEG_LINE     = 3'd2;
  localparam logic [2:0] OP_LINE_LINE    = 3'd3;
  localparam logic [2:0] OP_LINE_SEG_END = 3'd4;

  localparam logic [2:0] KIND_PARALLEL = 3'd0;
  localparam logic [2:0] KIND_OUTSIDE  = 3'd1;
  localparam logic [2:0] KIND_INSIDE   = 3'd2;
  localparam logic [2:0] KIND_FIRST    = 3'd3;
  localparam logic [2:0] KIND_SECOND   = 3'd4;
  localparam logic [2:0] KIND_BOTH     = 3'd5;
  localparam logic [2:0] KIND_AT_S1    = 3'd6;
  localparam logic [2:0] KIND_AT_S2    = 3'd7;

  localparam logic [1:0] ORIENT_PAR = 2'd0;
  localparam logic [1:0] ORIENT_POS = 2'd1;
  localparam logic [1:0] ORIENT_NEG = 2'd2;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] first_start_x;
    logic signed [31:0] first_start_y;
    logic signed [31:0] first_end_x;
    logic signed [31:0] first_end_y;
    logic signed [31:0] second_start_x;
    logic signed [31:0] second_start_y;
    logic signed [31:0] second_end_x;
    logic signed [31:0] second_end_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [2:0]         kind;
    logic [1:0]         orientation;
    logic               point_saturated;
  } out_item_t;

  // Item data that rides alongside the arithmetic.
  typedef struct packed {
    logic [1:0] orient;
    in_item_t   item;
  } meta_t;

  typedef struct packed {
    logic signed [99:0] nx;
    logic signed [99:0] ny;
    logic signed [66:0] det;
  } num_t;

  typedef struct packed {
    logic [31:0] qx;
    logic [31:0] qy;
    logic        bigx;
    logic        bigy;
    logic        negx;
    logic        negy;
  } qres_t;

endpackage

FILE: hdl/sic_front.sv
module sic_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_valid,
  input  sic_pkg::in_item_t     in_item,
  input  logic [62:0]           par_tol,
  output logic                  num_valid,
  output sic_pkg::meta_t        num_meta,
  output sic_pkg::num_t         num
);

  // Stage A: line coefficients.
  logic va_r;
  sic_pkg::in_item_t item_a_r;
  logic signed [32:0] a1_a_r, b1_a_r, a2_a_r, b2_a_r;

  // Stage B: first products.
  logic vb_r;
  sic_pkg::in_item_t item_b_r;
  logic signed [32:0] a1_b_r, b1_b_r, a2_b_r, b2_b_r;
  logic signed [64:0] p1_b_r, p2_b_r, p3_b_r, p4_b_r;
  logic signed [65:0] p5_b_r, p6_b_r;

  // Stage C: right-hand sides and determinant.
  logic vc_r;
  sic_pkg::in_item_t item_c_r;
  logic signed [32:0] a1_c_r, b1_c_r, a2_c_r, b2_c_r;
  logic signed [65:0] c1_c_r, c2_c_r;
  logic signed [66:0] det_c_r;

  // Stage D: numerator partial products, split at bit 33 of c.
  logic vd_r;
  sic_pkg::meta_t meta_d_r;
  logic signed [66:0] det_d_r;
  logic signed [65:0] b2c1h_r, b1c2h_r, a1c2h_r, a2c1h_r;
  logic signed [66:0] b2c1l_r, b1c2l_r, a1c2l_r, a2c1l_r;

  // Stage E: full numerators.
  logic ve_r;
  sic_pkg::meta_t meta_e_r;
  sic_pkg::num_t num_e_r;

  logic signed [33:0] c1l, c2l;
  logic signed [32:0] c1h, c2h;
  logic signed [66:0] tol_s;
  logic [1:0] orient_nxt;
  logic signed [66:0] dhx, dhy;
  logic signed [67:0] dlx, dly;
  sic_pkg::num_t num_nxt;

  always_comb begin
    c1l = signed'({1'b0, c1_c_r[32:0]});
    c2l = signed'({1'b0, c2_c_r[32:0]});
    c1h = signed'(c1_c_r[65:33]);
    c2h = signed'(c2_c_r[65:33]);
    tol_s = signed'({4'b0, par_tol});
    if (det_c_r > tol_s) begin
      orient_nxt = sic_pkg::ORIENT_POS;
    end else if (det_c_r < -tol_s) begin
      orient_nxt = sic_pkg::ORIENT_NEG;
    end else begin
      orient_nxt = sic_pkg::ORIENT_PAR;
    end
  end

  always_comb begin
    dhx = 67'(b2c1h_r) - 67'(b1c2h_r);
    dlx = 68'(b2c1l_r) - 68'(b1c2l_r);
    dhy = 67'(a1c2h_r) - 67'(a2c1h_r);
    dly = 68'(a1c2l_r) - 68'(a2c1l_r);
    num_nxt.nx  = (100'(dhx) <<< 33) + 100'(dlx);
    num_nxt.ny  = (100'(dhy) <<< 33) + 100'(dly);
    num_nxt.det = det_d_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_a_r <= in_item;
      a1_a_r   <= 33'(in_item.first_end_y) - 33'(in_item.first_start_y);
      b1_a_r   <= 33'(in_item.first_start_x) - 33'(in_item.first_end_x);
      a2_a_r   <= 33'(in_item.second_end_y) - 33'(in_item.second_start_y);
      b2_a_r   <= 33'(in_item.second_start_x) - 33'(in_item.second_end_x);

      item_b_r <= item_a_r;
      a1_b_r   <= a1_a_r;
      b1_b_r   <= b1_a_r;
      a2_b_r   <= a2_a_r;
      b2_b_r   <= b2_a_r;
      p1_b_r   <= 65'(a1_a_r) * 65'(item_a_r.first_start_x);
      p2_b_r   <= 65'(b1_a_r) * 65'(item_a_r.first_start_y);
      p3_b_r   <= 65'(a2_a_r) * 65'(item_a_r.second_start_x);
      p4_b_r   <= 65'(b2_a_r) * 65'(item_a_r.second_start_y);
      p5_b_r   <= 66'(a1_a_r) * 66'(b2_a_r);
      p6_b_r   <= 66'(a2_a_r) * 66'(b1_a_r);

      item_c_r <= item_b_r;
      a1_c_r   <= a1_b_r;
      b1_c_r   <= b1_b_r;
      a2_c_r   <= a2_b_r;
      b2_c_r   <= b2_b_r;
      c1_c_r   <= 66'(p1_b_r) + 66'(p2_b_r);
      c2_c_r   <= 66'(p3_b_r) + 66'(p4_b_r);
      det_c_r  <= 67'(p5_b_r) - 67'(p6_b_r);

      meta_d_r.item   <= item_c_r;
      meta_d_r.orient <= orient_nxt;
      det_d_r <= det_c_r;
      b2c1h_r <= 66'(b2_c_r) * 66'(c1h);
      b1c2h_r <= 66'(b1_c_r) * 66'(c2h);
      a1c2h_r <= 66'(a1_c_r) * 66'(c2h);
      a2c1h_r <= 66'(a2_c_r) * 66'(c1h);
      b2c1l_r <= 67'(b2_c_r) * 67'(c1l);
      b1c2l_r <= 67'(b1_c_r) * 67'(c2l);
      a1c2l_r <= 67'(a1_c_r) * 67'(c2l);
      a2c1l_r <= 67'(a2_c_r) * 67'(c1l);

      meta_e_r <= meta_d_r;
      num_e_r  <= num_nxt;
    end
  end

  assign num_valid = ve_r;
  assign num_meta  = meta_e_r;
  assign num       = num_e_r;

endmodule

FILE: hdl/sic_div.sv
module sic_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            num_valid,
  input  sic_pkg::meta_t  num_meta,
  input  sic_pkg::num_t   num,
  output logic            q_valid,
  output sic_pkg::meta_t  q_meta,
  output sic_pkg::qres_t  qres
);

  typedef struct packed {
    logic [66:0] rem;
    logic [31:0] nlow;
    logic [31:0] quo;
    logic        big;
    logic        neg;
  } lane_t;

  function automatic lane_t div_step(lane_t l, logic [66:0] d);
    lane_t o;
    logic [67:0] t;
    logic [67:0] diff;
    o    = l;
    t    = {l.rem, l.nlow[31]};
    diff = t - {1'b0, d};
    o.nlow = {l.nlow[30:0], 1'b0};
    if (t >= {1'b0, d}) begin
      o.rem = diff[66:0];
      o.quo = {l.quo[30:0], 1'b1};
    end else begin
      o.rem = t[66:0];
      o.quo = {l.quo[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic lane_t div_init(logic signed [99:0] n, logic [66:0] dabs,
                                     logic dneg);
    lane_t o;
    logic [99:0] nabs;
    nabs  = n[99] ? 100'(-n) : 100'(n);
    o.neg = n[99] ^ dneg;
    // A quotient of 2^32 or more saturates whatever its exact value.
    o.big  = nabs >= {1'b0, dabs, 32'b0};
    o.rem  = nabs[98:32];
    o.nlow = nabs[31:0];
    o.quo  = '0;
    return o;
  endfunction

  logic [66:0] dabs;
  assign dabs = num.det[66] ? 67'(-num.det) : 67'(num.det);

  logic vf_r;
  sic_pkg::meta_t meta_f_r;
  logic [66:0] d_f_r;
  lane_t lx_f_r, ly_f_r;

  logic vs_r [sic_pkg::DIV_BITS];
  sic_pkg::meta_t meta_s_r [sic_pkg::DIV_BITS];
  logic [66:0] d_s_r [sic_pkg::DIV_BITS];
  lane_t lx_s_r [sic_pkg::DIV_BITS];
  lane_t ly_s_r [sic_pkg::DIV_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (adv) begin
      vf_r <= num_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_f_r <= num_meta;
      d_f_r    <= dabs;
      lx_f_r   <= div_init(num.nx, dabs, num.det[66]);
      ly_f_r   <= div_init(num.ny, dabs, num.det[66]);
    end
  end

  for (genvar k = 0; k < sic_pkg::DIV_BITS; k++) begin : g_step
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vs_r[k] <= 1'b0;
        end else if (adv) begin
          vs_r[k] <= vf_r;
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          meta_s_r[k] <= meta_f_r;
          d_s_r[k]    <= d_f_r;
          lx_s_r[k]   <= div_step(lx_f_r, d_f_r);
          ly_s_r[k]   <= div_step(ly_f_r, d_f_r);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vs_r[k] <= 1'b0;
        end else if (adv) begin
          vs_r[k] <= vs_r[k-1];
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          meta_s_r[k] <= meta_s_r[k-1];
          d_s_r[k]    <= d_s_r[k-1];
          lx_s_r[k]   <= div_step(lx_s_r[k-1], d_s_r[k-1]);
          ly_s_r[k]   <= div_step(ly_s_r[k-1], d_s_r[k-1]);
        end
      end
    end
  end

  assign q_valid   = vs_r[sic_pkg::DIV_BITS-1];
  assign q_meta    = meta_s_r[sic_pkg::DIV_BITS-1];
  assign qres.qx   = lx_s_r[sic_pkg::DIV_BITS-1].quo;
  assign qres.qy   = ly_s_r[sic_pkg::DIV_BITS-1].quo;
  assign qres.bigx = lx_s_r[sic_pkg::DIV_BITS-1].big;
  assign qres.bigy = ly_s_r[sic_pkg::DIV_BITS-1].big;
  assign qres.negx = lx_s_r[sic_pkg::DIV_BITS-1].neg;
  assign qres.negy = ly_s_r[sic_pkg::DIV_BITS-1].neg;

endmodule

FILE: hdl/sic_classify.sv
module sic_classify (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 q_valid,
  input  sic_pkg::meta_t       q_meta,
  input  sic_pkg::qres_t       qres,
  input  logic [30:0]          vtx_tol,
  output logic                 out_valid,
  output sic_pkg::out_item_t   out_item
);

  function automatic logic [32:0] sat_coord(logic [31:0] q, logic big, logic neg);
    logic [32:0] o;
    if (!neg) begin
      if (big || q[31]) o = {1'b1, 32'h7FFF_FFFF};
      else o = {1'b0, q};
    end else begin
      if (big || q > 32'h8000_0000) o = {1'b1, 32'h8000_0000};
      else o = {1'b0, 32'(-q)};
    end
    return o;
  endfunction

  logic [61:0] vsq_r;

  // Stage G: signed, saturated point.
  logic vg_r;
  sic_pkg::meta_t meta_g_r;
  logic signed [31:0] px_g_r, py_g_r;
  logic sat_g_r;

  // Stage H: squared distances to each vertex and the two dot products.
  logic vh_r;
  sic_pkg::meta_t meta_h_r;
  logic signed [31:0] px_h_r, py_h_r;
  logic sat_h_r;
  logic [65:0] sqx_h_r [4];
  logic [65:0] sqy_h_r [4];
  logic signed [65:0] dotr_x_r, dotr_y_r, dots_x_r, dots_y_r;

  logic vo_r;
  sic_pkg::out_item_t out_r;

  logic [32:0] sx, sy;
  logic signed [32:0] dx [4];
  logic signed [32:0] dy [4];
  logic near [4];
  logic out_r_seg, out_s_seg, fo, so;
  logic [66:0] vsh;
  logic [2:0] kind_nxt;

  always_comb begin
    sx = sat_coord(qres.qx, qres.bigx, qres.negx);
    sy = sat_coord(qres.qy, qres.bigy, qres.negy);
    if (q_meta.orient == sic_pkg::ORIENT_PAR) begin
      sx = '0;
      sy = '0;
    end
  end

  always_comb begin
    dx[0] = 33'(px_g_r) - 33'(meta_g_r.item.first_start_x);
    dy[0] = 33'(py_g_r) - 33'(meta_g_r.item.first_start_y);
    dx[1] = 33'(px_g_r) - 33'(meta_g_r.item.first_end_x);
    dy[1] = 33'(py_g_r) - 33'(meta_g_r.item.first_end_y);
    dx[2] = 33'(px_g_r) - 33'(meta_g_r.item.second_start_x);
    dy[2] = 33'(py_g_r) - 33'(meta_g_r.item.second_start_y);
    dx[3] = 33'(px_g_r) - 33'(meta_g_r.item.second_end_x);
    dy[3] = 33'(py_g_r) - 33'(meta_g_r.item.second_end_y);
  end

  always_comb begin
    vsh = {36'b0, vtx_tol} << sic_pkg::FRAC;
    for (int i = 0; i < 4; i++) begin
      near[i] = ({1'b0, sqx_h_r[i]} + {1'b0, sqy_h_r[i]}) < {5'b0, vsq_r};
    end
    out_r_seg = (67'(dotr_x_r) + 67'(dotr_y_r)) > signed'(vsh);
    out_s_seg = (67'(dots_x_r) + 67'(dots_y_r)) > signed'(vsh);
    fo = near[0] || near[1];
    so = near[2] || near[3];
    kind_nxt = sic_pkg::KIND_INSIDE;
    if (meta_h_r.orient == sic_pkg::ORIENT_PAR) begin
      kind_nxt = sic_pkg::KIND_PARALLEL;
    end else begin
      unique case (meta_h_r.item.operation)
        sic_pkg::OP_SEG_SEG: begin
          if (out_r_seg || out_s_seg) kind_nxt = sic_pkg::KIND_OUTSIDE;
          else if (fo && so) kind_nxt = sic_pkg::KIND_BOTH;
          else if (fo) kind_nxt = sic_pkg::KIND_FIRST;
          else if (so) kind_nxt = sic_pkg::KIND_SECOND;
        end
        sic_pkg::OP_LINE_SEG: begin
          if (out_s_seg) kind_nxt = sic_pkg::KIND_OUTSIDE;
          else if (so) kind_nxt = sic_pkg::KIND_SECOND;
        end
        sic_pkg::OP_SEG_LINE: begin
          if (out_r_seg) kind_nxt = sic_pkg::KIND_OUTSIDE;
          else if (fo) kind_nxt = sic_pkg::KIND_FIRST;
        end
        sic_pkg::OP_LINE_SEG_END: begin
          if (out_s_seg) kind_nxt = sic_pkg::KIND_OUTSIDE;
          else if (near[2]) kind_nxt = sic_pkg::KIND_AT_S1;
          else if (near[3]) kind_nxt = sic_pkg::KIND_AT_S2;
        end
        default: begin
          kind_nxt = sic_pkg::KIND_INSIDE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    vsq_r <= 62'(vtx_tol) * 62'(vtx_tol);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r <= 1'b0;
      vh_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      vg_r <= q_valid;
      vh_r <= vg_r;
      vo_r <= vh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_g_r <= q_meta;
      px_g_r   <= signed'(sx[31:0]);
      py_g_r   <= signed'(sy[31:0]);
      sat_g_r  <= sx[32] | sy[32];

      meta_h_r <= meta_g_r;
      px_h_r   <= px_g_r;
      py_h_r   <= py_g_r;
      sat_h_r  <= sat_g_r;
      for (int i = 0; i < 4; i++) begin
        sqx_h_r[i] <= 66'(66'(dx[i]) * 66'(dx[i]));
        sqy_h_r[i] <= 66'(66'(dy[i]) * 66'(dy[i]));
      end
      dotr_x_r <= 66'(dx[0]) * 66'(dx[1]);
      dotr_y_r <= 66'(dy[0]) * 66'(dy[1]);
      dots_x_r <= 66'(dx[2]) * 66'(dx[3]);
      dots_y_r <= 66'(dy[2]) * 66'(dy[3]);

      out_r.point_x         <= px_h_r;
      out_r.point_y         <= py_h_r;
      out_r.point_saturated <= sat_h_r;
      out_r.orientation     <= meta_h_r.orient;
      out_r.kind            <= kind_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_item  = out_r;

endmodule

FILE: hdl/segment_intersection_classifier.sv
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   sic_pkg::in_item_t (operation, two segments)
// out_      output     out_valid/out_stall sic_pkg::out_item_t (point, kind, orientation)
// cfg_      input      cfg_wr_en           cfg_index, cfg_data (tolerance registers)
//
// One item enters and one result leaves per clock unless the result side stalls; the
// divider is a 32-step restoring divider that produces one quotient bit per stage.
// Reset clears every stage valid bit and loads the default tolerances.
// A stall on the result side freezes the whole pipeline, the output register included,
// and raises in_stall in the same cycle, so no item is lost or duplicated.
module segment_intersection_classifier (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sic_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output sic_pkg::out_item_t  out_item,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [62:0]         cfg_data
);

  // Tolerance registers. A write of zero leaves the register unchanged.
  logic [62:0] par_tol_r;
  logic [30:0] vtx_tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      par_tol_r <= sic_pkg::PAR_TOL_RESET;
      vtx_tol_r <= sic_pkg::VTX_TOL_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sic_pkg::CFG_PAR_TOL: begin
          if (cfg_data != '0) par_tol_r <= cfg_data;
        end
        sic_pkg::CFG_VTX_TOL: begin
          if (cfg_data[30:0] != '0) vtx_tol_r <= cfg_data[30:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The pipeline advances whenever the output register is empty or being taken.
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  logic           num_valid;
  sic_pkg::meta_t num_meta;
  sic_pkg::num_t  num;
  logic           q_valid;
  sic_pkg::meta_t q_meta;
  sic_pkg::qres_t qres;

  // Coefficients, determinant, orientation and the Cramer numerators.
  sic_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .par_tol   (par_tol_r),
    .num_valid (num_valid),
    .num_meta  (num_meta),
    .num       (num)
  );

  // Magnitude division for both coordinates, with an early overflow flag.
  sic_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .num_valid (num_valid),
    .num_meta  (num_meta),
    .num       (num),
    .q_valid   (q_valid),
    .q_meta    (q_meta),
    .qres      (qres)
  );

  // Saturation, vertex and segment tests, and the output register.
  sic_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .q_valid   (q_valid),
    .q_meta    (q_meta),
    .qres      (qres),
    .vtx_tol   (vtx_tol_r),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // A parallel result carries a zero point and the parallel kind.
  a_parallel_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.orientation == sic_pkg::ORIENT_PAR |->
      out_item.point_x == 0 && out_item.point_y == 0 &&
      out_item.kind == sic_pkg::KIND_PARALLEL && !out_item.point_saturated)
    else $error("parallel result with nonzero point or kind");

  // A non-parallel result is never classified as parallel.
  a_nonpar_kind : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.orientation != sic_pkg::ORIENT_PAR |->
      out_item.kind != sic_pkg::KIND_PARALLEL)
    else $error("non-parallel result classified as parallel");

  // A saturated point has at least one coordinate at the edge of the range.
  a_sat_edge : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.point_saturated |->
      out_item.point_x == 32'sh7FFF_FFFF || out_item.point_x == -32'sh8000_0000 ||
      out_item.point_y == 32'sh7FFF_FFFF || out_item.point_y == -32'sh8000_0000)
    else $error("saturated flag without a clamped coordinate");

endmodule

FILE: dv/segment_intersection_classifier_test.sv
module segment_intersection_classifier_test;
  timeunit 1ns;
  timeprecision 1ps;

  // The pipeline is 41 stages deep, so a margin of DRAIN_CYCLES covers the drain.
  localparam int DRAIN_CYCLES = 200;
  localparam int IDLE_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  sic_pkg::in_item_t in_item;
  logic out_valid;
  logic out_stall;
  sic_pkg::out_item_t out_item;
  logic cfg_wr_en;
  logic cfg_index;
  logic [62:0] cfg_data;

  segment_intersection_classifier i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // The testbench keeps its own copy of both tolerance registers.
  logic [62:0] det_tol;
  logic [30:0] vtx_tol;

  // Predicted results wait here until the block hands them over, oldest first.
  sic_pkg::out_item_t pending_points[$];
  int error_count;
  int idle_cycles;
  bit timed_out;
  bit recv_stall_heavy;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Truncating signed division clamped to 32 bits; sets sat when clamped.
  function automatic logic signed [31:0] clamp_quotient(input logic signed [127:0] num,
                                                         input logic signed [127:0] den,
                                                         inout logic sat);
    logic signed [127:0] q;
    q = num / den;
    if (q > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (q < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return q[31:0];
  endfunction

  function automatic bit near_point(input logic signed [31:0] px, input logic signed [31:0] py,
                                    input logic signed [31:0] qx, input logic signed [31:0] qy);
    logic signed [127:0] dx, dy, v;
    dx = 128'(px) - 128'(qx);
    dy = 128'(py) - 128'(qy);
    v = $signed({97'd0, vtx_tol});
    return (dx * dx + dy * dy) < v * v;
  endfunction

  // The tolerance enters this test unsquared, shifted up by the fraction bits.
  function automatic bit beyond_segment(input logic signed [31:0] px,
                                        input logic signed [31:0] py,
                                        input logic signed [31:0] ax,
                                        input logic signed [31:0] ay,
                                        input logic signed [31:0] bx,
                                        input logic signed [31:0] by);
    logic signed [127:0] dot, v;
    dot = (128'(px) - 128'(ax)) * (128'(px) - 128'(bx))
        + (128'(py) - 128'(ay)) * (128'(py) - 128'(by));
    v = $signed({97'd0, vtx_tol}) <<< sic_pkg::FRAC;
    return dot > v;
  endfunction

  function automatic sic_pkg::out_item_t classify_pair(input sic_pkg::in_item_t it);
    sic_pkg::out_item_t res;
    logic signed [127:0] a1, b1, a2, b2, c1, c2, det, tol;
    logic signed [31:0] px, py;
    logic sat;
    bit out_r, out_s, near_r, near_s;
    a1 = 128'(it.first_end_y) - 128'(it.first_start_y);
    b1 = 128'(it.first_start_x) - 128'(it.first_end_x);
    a2 = 128'(it.second_end_y) - 128'(it.second_start_y);
    b2 = 128'(it.second_start_x) - 128'(it.second_end_x);
    c1 = a1 * 128'(it.first_start_x) + b1 * 128'(it.first_start_y);
    c2 = a2 * 128'(it.second_start_x) + b2 * 128'(it.second_start_y);
    det = a1 * b2 - a2 * b1;
    tol = $signed({65'd0, det_tol});
    res = '0;
    if (det > tol) res.orientation = sic_pkg::ORIENT_POS;
    else if (det < -tol) res.orientation = sic_pkg::ORIENT_NEG;
    else return res;
    sat = 1'b0;
    px = clamp_quotient(b2 * c1 - b1 * c2, det, sat);
    py = clamp_quotient(a1 * c2 - a2 * c1, det, sat);
    res.point_x = px;
    res.point_y = py;
    res.point_saturated = sat;
    out_r = beyond_segment(px, py, it.first_start_x, it.first_start_y,
                           it.first_end_x, it.first_end_y);
    out_s = beyond_segment(px, py, it.second_start_x, it.second_start_y,
                           it.second_end_x, it.second_end_y);
    near_r = near_point(px, py, it.first_start_x, it.first_start_y) ||
             near_point(px, py, it.first_end_x, it.first_end_y);
    near_s = near_point(px, py, it.second_start_x, it.second_start_y) ||
             near_point(px, py, it.second_end_x, it.second_end_y);
    res.kind = sic_pkg::KIND_INSIDE;
    case (it.operation)
      sic_pkg::OP_SEG_SEG: begin
        if (out_r || out_s) res.kind = sic_pkg::KIND_OUTSIDE;
        else if (near_r && near_s) res.kind = sic_pkg::KIND_BOTH;
        else if (near_r) res.kind = sic_pkg::KIND_FIRST;
        else if (near_s) res.kind = sic_pkg::KIND_SECOND;
      end
      sic_pkg::OP_LINE_SEG: begin
        if (out_s) res.kind = sic_pkg::KIND_OUTSIDE;
        else if (near_s) res.kind = sic_pkg::KIND_SECOND;
      end
      sic_pkg::OP_SEG_LINE: begin
        if (out_r) res.kind = sic_pkg::KIND_OUTSIDE;
        else if (near_r) res.kind = sic_pkg::KIND_FIRST;
      end
      sic_pkg::OP_LINE_SEG_END: begin
        if (out_s) res.kind = sic_pkg::KIND_OUTSIDE;
        else if (near_point(px, py, it.second_start_x, it.second_start_y))
          res.kind = sic_pkg::KIND_AT_S1;
        else if (near_point(px, py, it.second_end_x, it.second_end_y))
          res.kind = sic_pkg::KIND_AT_S2;
      end
      default: ;  // Line/line and the unused codes are always inside.
    endcase
    return res;
  endfunction

  // Receiver: stalls in phases, sometimes heavily, sometimes lightly.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (recv_stall_heavy) out_stall <= ($urandom_range(0, 3) != 0);
      else out_stall <= ($urandom_range(0, 7) == 0);
    end
  end

  // Checks every result the block hands over against the oldest prediction.
  always @(posedge clk) begin
    sic_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        report_mismatch("result with no prediction", 64'(out_item), 64'd0);
      end else begin
        want = pending_points.pop_front();
        if (out_item.point_x !== want.point_x)
          report_mismatch("point_x", 64'(out_item.point_x), 64'(want.point_x));
        if (out_item.point_y !== want.point_y)
          report_mismatch("point_y", 64'(out_item.point_y), 64'(want.point_y));
        if (out_item.kind !== want.kind)
          report_mismatch("kind", 64'(out_item.kind), 64'(want.kind));
        if (out_item.orientation !== want.orientation)
          report_mismatch("orientation", 64'(out_item.orientation), 64'(want.orientation));
        if (out_item.point_saturated !== want.point_saturated)
          report_mismatch("point_saturated", 64'(out_item.point_saturated),
                          64'(want.point_saturated));
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sends one item, holding it until accepted, and records its prediction.
  // Valid stays high after acceptance so a following item can go in the very next
  // cycle; a random gap, or a caller going idle, drops it first.
  task automatic send_pair(input sic_pkg::in_item_t it, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    pending_points.push_back(classify_pair(it));
  endtask

  // Bursts: some items go back to back, then a random gap.
  int burst_left;
  task automatic send_bursty(input sic_pkg::in_item_t it);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
    end
    burst_left--;
    send_pair(it, gap);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes go only to an idle block; a zero write must leave the register alone.
  task automatic write_register(input logic idx, input logic [62:0] value);
    wait_drained();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == sic_pkg::CFG_PAR_TOL) begin
      if (value != 0) det_tol = value;
    end else begin
      if (value[30:0] != 0) vtx_tol = value[30:0];
    end
  endtask

  function automatic logic signed [31:0] pick_coord(input int scale);
    case (scale)
      0: return $signed(32'($urandom_range(0, 40)) - 20) <<< sic_pkg::FRAC;
      1: return $signed(32'($urandom_range(0, 2000000)) - 1000000);
      default: return $signed($urandom);
    endcase
  endfunction

  // Random pair. Some pairs share or touch endpoints so vertex kinds appear,
  // some are nearly parallel, and a few use raw 32-bit values.
  function automatic sic_pkg::in_item_t random_pair();
    sic_pkg::in_item_t it;
    int scale;
    it.operation = $urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
    scale = $urandom_range(0, 9) < 5 ? 0 : ($urandom_range(0, 3) == 0 ? 2 : 1);
    it.first_start_x = pick_coord(scale);
    it.first_start_y = pick_coord(scale);
    it.first_end_x = pick_coord(scale);
    it.first_end_y = pick_coord(scale);
    it.second_start_x = pick_coord(scale);
    it.second_start_y = pick_coord(scale);
    it.second_end_x = pick_coord(scale);
    it.second_end_y = pick_coord(scale);
    case ($urandom_range(0, 5))
      0: begin
        it.second_start_x = it.first_end_x;
        it.second_start_y = it.first_end_y;
      end
      1: begin
        it.second_end_x = it.first_start_x + 32'($urandom_range(0, 4));
        it.second_end_y = it.first_start_y;
      end
      2: begin
        // Parallel or nearly so: the second segment is a shifted copy.
        it.second_end_x = it.second_start_x + (it.first_end_x - it.first_start_x);
        it.second_end_y = it.second_start_y + (it.first_end_y - it.first_start_y)
                          + 32'($urandom_range(0, 2));
      end
      default: ;
    endcase
    return it;
  endfunction

  function automatic sic_pkg::in_item_t make_pair(input logic [2:0] op,
      input logic signed [31:0] r1x, input logic signed [31:0] r1y,
      input logic signed [31:0] r2x, input logic signed [31:0] r2y,
      input logic signed [31:0] s1x, input logic signed [31:0] s1y,
      input logic signed [31:0] s2x, input logic signed [31:0] s2y);
    sic_pkg::in_item_t it;
    it.operation = op;
    it.first_start_x = r1x;
    it.first_start_y = r1y;
    it.first_end_x = r2x;
    it.first_end_y = r2y;
    it.second_start_x = s1x;
    it.second_start_y = s1y;
    it.second_end_x = s2x;
    it.second_end_y = s2y;
    return it;
  endfunction

  // Crossing for all op codes; touching for ops 0-4; parallel, saturating, extreme pairs.
  task automatic test_directed();
    localparam logic signed [31:0] ONE = 32'sh10000;
    localparam logic signed [31:0] MAXC = 32'sh7fffffff;
    localparam logic signed [31:0] MINC = 32'sh80000000;
    logic [2:0] op;
    for (int k = 0; k < 8; k++) begin
      op = 3'(k);
      // Crossing in the middle of both.
      send_pair(make_pair(op, -ONE, -ONE, ONE, ONE, -ONE, ONE, ONE, -ONE), 0);
      // Crossing beyond both segments.
      send_pair(make_pair(op, 0, 0, ONE, 0, 5 * ONE, ONE, 5 * ONE, 2 * ONE), 0);
    end
    for (int k = 0; k < 5; k++) begin
      op = 3'(k);
      // Touching at shared endpoints and at the start and end of the second segment.
      send_pair(make_pair(op, 0, 0, 2 * ONE, 0, 2 * ONE, 0, 2 * ONE, 3 * ONE), 1);
      send_pair(make_pair(op, -ONE, 0, ONE, 0, 0, 0, 0, ONE), 0);
      send_pair(make_pair(op, -ONE, 0, ONE, 0, 0, -ONE, 0, 0), 0);
    end
    // Parallel and degenerate pairs.
    send_pair(make_pair(sic_pkg::OP_SEG_SEG, 0, 0, ONE, ONE, ONE, 0, 2 * ONE, ONE), 0);
    send_pair(make_pair(sic_pkg::OP_LINE_LINE, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    // Full-range coordinates, some of which saturate the point.
    send_pair(make_pair(sic_pkg::OP_SEG_SEG, MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC,
                        MINC), 0);
    send_pair(make_pair(sic_pkg::OP_LINE_LINE, MINC, 0, MINC, 1, MAXC, 0, MAXC - 1, 1), 0);
    send_pair(make_pair(sic_pkg::OP_LINE_SEG, 0, MAXC, 1, MAXC, -1, MINC, 0, MINC + 1), 0);
    send_pair(make_pair(sic_pkg::OP_LINE_LINE, 32'shffffffff, 0, 0, 0, 0, 32'shffffffff,
                        0, 0), 0);
    wait_drained();
  endtask

  // Random pairs in bursts with both channels idling at random.
  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 400 == 200) recv_stall_heavy = !recv_stall_heavy;
      send_bursty(random_pair());
    end
  endtask

  // The sender holds off until every prediction is matched, then resumes.
  task automatic test_full_drain_pause();
    test_random(100);
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    test_random(100);
  endtask

  // Walks the tolerances through extremes, zero writes included.
  task automatic test_tolerances();
    write_register(sic_pkg::CFG_PAR_TOL, 63'd1);
    write_register(sic_pkg::CFG_VTX_TOL, 63'd1);
    test_random(250);
    write_register(sic_pkg::CFG_PAR_TOL, 63'h7fffffffffffffff);
    write_register(sic_pkg::CFG_VTX_TOL, 63'h7fffffff);
    test_random(100);
    write_register(sic_pkg::CFG_PAR_TOL, 63'd0);
    write_register(sic_pkg::CFG_VTX_TOL, 63'd0);
    test_random(50);
    write_register(sic_pkg::CFG_PAR_TOL, 63'($urandom) << 20);
    write_register(sic_pkg::CFG_VTX_TOL, 63'h7fff0000 | 63'h5a5a);
    test_random(150);
    write_register(sic_pkg::CFG_PAR_TOL, 63'($urandom_range(1, 1 << 30)));
    write_register(sic_pkg::CFG_VTX_TOL, 63'($urandom_range(1, 1 << 20)));
    test_random(250);
    write_register(sic_pkg::CFG_PAR_TOL, sic_pkg::PAR_TOL_RESET);
    write_register(sic_pkg::CFG_VTX_TOL, 63'(sic_pkg::VTX_TOL_RESET));
    test_random(100);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_wr_en = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    det_tol = sic_pkg::PAR_TOL_RESET;
    vtx_tol = sic_pkg::VTX_TOL_RESET;
    error_count = 0;
    idle_cycles = 0;
    burst_left = 0;
    recv_stall_heavy = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(450);
    test_full_drain_pause();
    test_tolerances();

    wait_drained();
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/sic_pkg.sv
hdl/sic_front.sv
hdl/sic_div.sv
hdl/sic_classify.sv
hdl/segment_intersection_classifier.sv
dv/segment_intersection_classifier_test.sv
